FILE: rtl/core/msg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msg_pkg
// Shared types and constants of the multi-stop gradient sampler: stop entry
// layout, colour vectors, operation and register codes, and the records
// that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package msg_pkg;

  localparam int POS_W  = 16;
  localparam int CHAN_W = 8;
  localparam int NUM_CH = 4;
  localparam int PROD_W = CHAN_W + POS_W;
  localparam int QUOT_W = CHAN_W;
  localparam int REG_IDX_W = 3;

  // Input operation codes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_STOP_COUNT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SOLID_RED   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SOLID_GREEN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SOLID_BLUE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SOLID_ALPHA = 3'd4;

  localparam logic [CHAN_W-1:0] SOLID_ALPHA_RESET = 8'hFF;

  // Channel order inside a colour vector: 0 red, 1 green, 2 blue, 3 alpha.
  typedef logic [NUM_CH-1:0][CHAN_W-1:0] rgba_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    rgba_t            color;
  } stop_t;

  // Interpolation operands: result = base +/- floor-adjusted mag*num/span.
  typedef struct packed {
    logic              valid;
    rgba_t             base;
    logic [NUM_CH-1:0] neg;
    rgba_t             mag;
    logic [POS_W-1:0]  num;
    logic [POS_W-1:0]  span;
  } lerp_op_t;

  // One step of the restoring divider.
  typedef struct packed {
    logic                          valid;
    rgba_t                         base;
    logic [NUM_CH-1:0]             neg;
    logic [NUM_CH-1:0][PROD_W-1:0] rem;
    logic [NUM_CH-1:0][QUOT_W-1:0] quot;
    logic [POS_W-1:0]              span;
  } div_op_t;

endpackage
`default_nettype wire

FILE: rtl/core/multi_stop_gradient_sampler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_stop_gradient_sampler_core
// Samples a piecewise-linear RGBA gradient held in a table of stops.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge where start is high and busy is
//   low. With op = write it loads stop_index with a position and colour and
//   gives no result. With op = sample it returns one colour for sample_t.
//   busy is high only during reset, so one transaction can be taken in every
//   cycle; writes and samples may be mixed freely, and a sample sees every
//   write taken before it.
//   A result is shown on out_red..out_alpha for one cycle with done high.
//   A sample passes the bracket search (three stages), one multiply stage,
//   the eight-stage restoring divider and the output register. The receiver
//   cannot stall. The user must write registers through wr_en, wr_index and
//   wr_data only while no sample is in flight; the block does not enforce
//   this. Reset clears the pipeline and the registers (solid alpha resets to
//   opaque); stop entries hold no value until written.
// ----------------------------------------------------------------------------
module multi_stop_gradient_sampler_core
  import msg_pkg::*;
#(
  parameter int MAX_STOPS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 op,
  input  logic [2:0]           stop_index,
  input  logic [POS_W-1:0]     stop_position,
  input  logic [CHAN_W-1:0]    stop_red,
  input  logic [CHAN_W-1:0]    stop_green,
  input  logic [CHAN_W-1:0]    stop_blue,
  input  logic [CHAN_W-1:0]    stop_alpha,
  input  logic [POS_W-1:0]     sample_t,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [CHAN_W-1:0]    wr_data,
  output logic                 done,
  output logic [CHAN_W-1:0]    out_red,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_blue,
  output logic [CHAN_W-1:0]    out_alpha
);

  localparam int IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int CNT_W = $clog2(MAX_STOPS + 1);

  logic [3:0]        stop_count;
  rgba_t             solid;
  logic [CNT_W-1:0]  stop_n;
  logic              accept;
  stop_t             wr_stop;
  lerp_op_t          lerp;
  div_op_t           prod;
  div_op_t           quo;
  rgba_t             result;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= '0;
      solid      <= {SOLID_ALPHA_RESET, 8'h00, 8'h00, 8'h00};
    end else if (wr_en) begin
      unique case (wr_index)
        REG_STOP_COUNT:  stop_count <= wr_data[3:0];
        REG_SOLID_RED:   solid[0]   <= wr_data;
        REG_SOLID_GREEN: solid[1]   <= wr_data;
        REG_SOLID_BLUE:  solid[2]   <= wr_data;
        REG_SOLID_ALPHA: solid[3]   <= wr_data;
        default: ;
      endcase
    end
  end

  // A count above the table size uses the whole table.
  assign stop_n = (int'(stop_count) > MAX_STOPS) ? CNT_W'(MAX_STOPS)
                                                 : CNT_W'(stop_count);

  assign wr_stop.pos   = stop_position;
  assign wr_stop.color = {stop_alpha, stop_blue, stop_green, stop_red};

  msg_select #(
    .MAX_STOPS (MAX_STOPS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_select (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (op),
    .stop_index (stop_index),
    .wr_stop    (wr_stop),
    .sample_t   (sample_t),
    .stop_n     (stop_n),
    .solid      (solid),
    .lerp       (lerp)
  );

  msg_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .lerp (lerp),
    .prod (prod)
  );

  msg_div u_div (
    .clk  (clk),
    .rst  (rst),
    .din  (prod),
    .dout (quo)
  );

  // A falling channel rounds the step up so that the result still floors.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (quo.neg[c]) begin
        result[c] = quo.base[c] - quo.quot[c] - CHAN_W'(quo.rem[c] != '0);
      end else begin
        result[c] = quo.base[c] + quo.quot[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= quo.valid;
    end
    out_red   <= result[0];
    out_green <= result[1];
    out_blue  <= result[2];
    out_alpha <= result[3];
  end

endmodule
`default_nettype wire

FILE: rtl/core/msg_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msg_select
// Stop table, bracket search and operand setup. Compares the sample against
// every stop, picks the bracketing pair, and forms channel deltas and the
// interpolation fraction.
// ----------------------------------------------------------------------------
module msg_select
  import msg_pkg::*;
#(
  parameter int MAX_STOPS = 8,
  parameter int IDX_W     = 3,
  parameter int CNT_W     = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             op,
  input  logic [2:0]       stop_index,
  input  stop_t            wr_stop,
  input  logic [POS_W-1:0] sample_t,
  input  logic [CNT_W-1:0] stop_n,
  input  rgba_t            solid,
  output lerp_op_t         lerp
);

  stop_t stop_table [MAX_STOPS];

  logic                 wr_ok;
  logic [IDX_W-1:0]     wr_idx;

  logic                 s1_valid;
  logic [POS_W-1:0]     s1_t;
  logic [MAX_STOPS-1:0] s1_le;
  logic [MAX_STOPS-1:0] s1_ge;

  logic [CNT_W-1:0]     n_m1;
  logic [IDX_W-1:0]     last_idx;
  logic                 found;
  logic [IDX_W-1:0]     eidx;
  logic [IDX_W-1:0]     sidx;
  logic                 use_solid;
  logic                 direct;

  logic                 s2_valid;
  logic [POS_W-1:0]     s2_t;
  logic                 s2_direct;
  rgba_t                s2_c0;
  rgba_t                s2_c1;
  logic [POS_W-1:0]     s2_ps;
  logic [POS_W-1:0]     s2_pe;

  logic                 direct3;
  lerp_op_t             lerp_next;

  // Writes beyond the table are dropped.
  assign wr_ok  = accept && (op == OP_WRITE) && (int'(stop_index) < MAX_STOPS);
  assign wr_idx = IDX_W'(stop_index);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      stop_table[wr_idx] <= wr_stop;
    end
  end

  // Stage 1: compare the sample against every stop as it is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (op == OP_SAMPLE);
    end
    s1_t <= sample_t;
    for (int i = 0; i < MAX_STOPS; i++) begin
      s1_le[i] <= sample_t <= stop_table[i].pos;
      s1_ge[i] <= sample_t >= stop_table[i].pos;
    end
  end

  // Stage 2: find the first stop at or above t and read the pair.
  assign n_m1     = stop_n - CNT_W'(1);
  assign last_idx = n_m1[IDX_W-1:0];

  always_comb begin
    found = 1'b0;
    eidx  = '0;
    for (int i = MAX_STOPS - 1; i >= 1; i--) begin
      if (s1_le[i] && (i < int'(stop_n))) begin
        found = 1'b1;
        eidx  = IDX_W'(i);
      end
    end
  end

  always_comb begin
    use_solid = 1'b0;
    direct    = 1'b1;
    sidx      = last_idx;
    priority if (stop_n == '0) begin
      use_solid = 1'b1;
    end else if (s1_le[0]) begin
      sidx = '0;
    end else if (s1_ge[last_idx]) begin
      sidx = last_idx;
    end else if (found) begin
      sidx   = eidx - IDX_W'(1);
      direct = 1'b0;
    end else begin
      sidx = last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_t      <= s1_t;
    s2_direct <= direct;
    s2_c0     <= use_solid ? solid : stop_table[sidx].color;
    s2_c1     <= stop_table[eidx].color;
    s2_ps     <= stop_table[sidx].pos;
    s2_pe     <= stop_table[eidx].pos;
  end

  // Stage 3: span, clamped offset and per-channel delta. A degenerate pair
  // or a sample at or below the start stop returns the start colour unchanged.
  assign direct3 = s2_direct || (s2_pe <= s2_ps) || (s2_t <= s2_ps);

  always_comb begin
    lerp_next       = '0;
    lerp_next.valid = s2_valid;
    lerp_next.base  = s2_c0;
    if (direct3) begin
      lerp_next.span = POS_W'(1);
    end else begin
      lerp_next.span = s2_pe - s2_ps;
      lerp_next.num  = (s2_t >= s2_pe) ? (s2_pe - s2_ps) : (s2_t - s2_ps);
      for (int c = 0; c < NUM_CH; c++) begin
        if (s2_c1[c] >= s2_c0[c]) begin
          lerp_next.mag[c] = s2_c1[c] - s2_c0[c];
        end else begin
          lerp_next.neg[c] = 1'b1;
          lerp_next.mag[c] = s2_c0[c] - s2_c1[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lerp.valid <= 1'b0;
    end else begin
      lerp.valid <= lerp_next.valid;
    end
    lerp.base <= lerp_next.base;
    lerp.neg  <= lerp_next.neg;
    lerp.mag  <= lerp_next.mag;
    lerp.num  <= lerp_next.num;
    lerp.span <= lerp_next.span;
  end

endmodule
`default_nettype wire

FILE: rtl/core/msg_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msg_mul
// Multiply stage: scales each channel delta by the offset into the span,
// producing the dividend for the divider.
// ----------------------------------------------------------------------------
module msg_mul
  import msg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  lerp_op_t lerp,
  output div_op_t  prod
);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else begin
      prod.valid <= lerp.valid;
    end
    prod.base <= lerp.base;
    prod.neg  <= lerp.neg;
    prod.span <= lerp.span;
    prod.quot <= '0;
    for (int c = 0; c < NUM_CH; c++) begin
      prod.rem[c] <= PROD_W'(lerp.mag[c]) * PROD_W'(lerp.num);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/msg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msg_div
// Pipelined restoring divider, one quotient bit per stage for all four
// channels. The quotient never exceeds the channel delta, so eight stages
// cover it, most significant bit first.
// ----------------------------------------------------------------------------
module msg_div
  import msg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  div_op_t din,
  output div_op_t dout
);

  div_op_t stg [QUOT_W+1];

  assign stg[0] = din;
  assign dout   = stg[QUOT_W];

  for (genvar s = 0; s < QUOT_W; s++) begin : g_step
    localparam int BIT = QUOT_W - 1 - s;

    logic [PROD_W-1:0] dsh;
    div_op_t           step_next;

    assign dsh = PROD_W'(stg[s].span) << BIT;

    always_comb begin
      step_next = stg[s];
      for (int c = 0; c < NUM_CH; c++) begin
        if (stg[s].rem[c] >= dsh) begin
          step_next.rem[c]       = stg[s].rem[c] - dsh;
          step_next.quot[c][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[s+1].valid <= 1'b0;
      end else begin
        stg[s+1].valid <= step_next.valid;
      end
      stg[s+1].base <= step_next.base;
      stg[s+1].neg  <= step_next.neg;
      stg[s+1].rem  <= step_next.rem;
      stg[s+1].quot <= step_next.quot;
      stg[s+1].span <= step_next.span;
    end
  end

endmodule
`default_nettype wire

FILE: bench/multi_stop_gradient_sampler_core_test.sv
// ----------------------------------------------------------------------------
// multi_stop_gradient_sampler_core_test
// Self-checking bench for the gradient sampler core. Stop writes and
// samples are queued and driven one per cycle with random sender gaps.
// Every accepted sample is predicted from a local copy of the stop table
// and the registers, and each strobed colour is checked channel by channel.
// ----------------------------------------------------------------------------
module multi_stop_gradient_sampler_core_test
  import msg_pkg::*;
();

  localparam int NUM_STOPS      = 8;
  localparam int RESULT_LATENCY = 13;
  localparam int SETTLE_CYCLES  = RESULT_LATENCY + 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 170;

  typedef struct packed {
    logic             op;
    logic [2:0]       idx;
    logic [POS_W-1:0] pos;
    rgba_t            color;
    logic [POS_W-1:0] t;
  } gradient_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  gradient_item_t       drive_item = '0;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [CHAN_W-1:0]    wr_data = '0;
  logic                 done;
  logic [CHAN_W-1:0]    out_red;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_blue;
  logic [CHAN_W-1:0]    out_alpha;

  gradient_item_t pending_items[$];
  rgba_t          expected_colors[$];
  int unsigned    error_count = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    idle_percent = 0;

  // Predictor copy of the block state.
  logic [POS_W-1:0] model_pos [NUM_STOPS];
  rgba_t            model_color [NUM_STOPS];
  logic [3:0]       model_count = 4'd0;
  rgba_t            model_solid = {SOLID_ALPHA_RESET, 24'h000000};

  // Stop positions as the stimulus generator has queued them.
  logic [POS_W-1:0] planned_pos [NUM_STOPS];

  multi_stop_gradient_sampler_core dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (drive_item.op),
    .stop_index    (drive_item.idx),
    .stop_position (drive_item.pos),
    .stop_red      (drive_item.color[0]),
    .stop_green    (drive_item.color[1]),
    .stop_blue     (drive_item.color[2]),
    .stop_alpha    (drive_item.color[3]),
    .sample_t      (drive_item.t),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .done          (done),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic rgba_t predict_color(input logic [POS_W-1:0] t);
    int     n;
    int     k;
    int     c;
    longint span;
    longint num;
    longint acc;
    rgba_t  res;
    n = (model_count > NUM_STOPS) ? NUM_STOPS : int'(model_count);
    if (n == 0) return model_solid;
    if (t <= model_pos[0]) return model_color[0];
    if (t >= model_pos[n-1]) return model_color[n-1];
    for (k = 1; k < n; k++) begin
      if (t <= model_pos[k]) begin
        span = longint'(model_pos[k]) - longint'(model_pos[k-1]);
        num = longint'(t) - longint'(model_pos[k-1]);
        if (span <= 0 || num <= 0) return model_color[k-1];
        if (num > span) num = span;
        for (c = 0; c < NUM_CH; c++) begin
          acc = longint'(model_color[k-1][c]) * span +
                (longint'(model_color[k][c]) - longint'(model_color[k-1][c])) * num;
          if (acc < 0) acc = 0;
          res[c] = CHAN_W'(acc / span);
        end
        return res;
      end
    end
    return model_color[n-1];
  endfunction

  function automatic void apply_gradient_item(input gradient_item_t item);
    if (item.op == OP_WRITE) begin
      if (item.idx < NUM_STOPS) begin
        model_pos[item.idx] = item.pos;
        model_color[item.idx] = item.color;
      end
    end else begin
      expected_colors = {expected_colors, predict_color(item.t)};
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Driver: a held transaction stays on the ports until busy drops.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_gradient_item(drive_item);
      if (!(start && busy)) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_percent) begin
          drive_item <= pending_items.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed colour is matched against the oldest prediction.
  always @(posedge clk) begin
    rgba_t got;
    rgba_t want;
    got = {out_alpha, out_blue, out_green, out_red};
    if (!rst && done) begin
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("colour %08h with no sample pending", got));
      end else begin
        want = expected_colors.pop_front();
        for (int c = 0; c < NUM_CH; c++) begin
          if (got[c] !== want[c])
            report_mismatch($sformatf("channel %0d got %02h expected %02h (colour %08h)",
                                      c, got[c], want[c], want));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("** multi_stop_gradient_sampler_core: FAILED **");
    $finish;
  end

  task automatic push_stop_write(input logic [2:0] idx, input logic [POS_W-1:0] pos,
                                 input rgba_t color);
    gradient_item_t item;
    item.op = OP_WRITE;
    item.idx = idx;
    item.pos = pos;
    item.color = color;
    item.t = POS_W'($urandom);
    pending_items = {pending_items, item};
    planned_pos[idx] = pos;
  endtask

  task automatic push_sample(input logic [POS_W-1:0] t);
    gradient_item_t item;
    item.op = OP_SAMPLE;
    item.idx = 3'($urandom);
    item.pos = POS_W'($urandom);
    item.color = rgba_t'($urandom);
    item.t = t;
    pending_items = {pending_items, item};
  endtask

  // Returns once every transaction is taken, every colour has come back and
  // the pipeline has had time to empty.
  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || start || expected_colors.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [CHAN_W-1:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    case (idx)
      REG_STOP_COUNT:  model_count = data[3:0];
      REG_SOLID_RED:   model_solid[0] = data;
      REG_SOLID_GREEN: model_solid[1] = data;
      REG_SOLID_BLUE:  model_solid[2] = data;
      REG_SOLID_ALPHA: model_solid[3] = data;
      default: ;
    endcase
  endtask

  task automatic end_register_writes();
    @(posedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random_phase(input int phase);
    logic [POS_W-1:0] set_pos [NUM_STOPS];
    logic [POS_W-1:0] swap;
    logic [CHAN_W-1:0] cfg;
    int counts [NUM_PHASES];
    int k;
    int j;
    int rot;
    int v;
    int lo;
    int hi;
    logic [2:0] idx;
    counts = '{8, 0, 15, 1, 0, 5, 9, 2};
    wait_until_drained();
    cfg = CHAN_W'($urandom);
    cfg[3:0] = 4'(counts[phase]);
    write_register(REG_STOP_COUNT, cfg);
    for (k = 0; k < NUM_CH; k++) begin
      if (phase == 1) cfg = 8'hFF;
      else if (phase == 4) cfg = 8'h00;
      else cfg = CHAN_W'($urandom);
      write_register(REG_SOLID_RED + REG_IDX_W'(k), cfg);
    end
    write_register(REG_IDX_W'($urandom_range(7, 5)), CHAN_W'($urandom));
    end_register_writes();
    case (phase % 3)
      0: idle_percent = 0;
      1: idle_percent = 51;
      default: idle_percent = 17;
    endcase

    // A fresh stop set; every fourth phase leaves it unsorted.
    for (k = 0; k < NUM_STOPS; k++) set_pos[k] = POS_W'($urandom);
    if (phase % 4 != 3) begin
      for (k = 0; k < NUM_STOPS; k++)
        for (j = 0; j < NUM_STOPS - 1 - k; j++)
          if (set_pos[j] > set_pos[j+1]) begin
            swap = set_pos[j];
            set_pos[j] = set_pos[j+1];
            set_pos[j+1] = swap;
          end
    end
    for (k = 1; k < NUM_STOPS; k++)
      if ($urandom_range(4) == 0) set_pos[k] = set_pos[k-1];
    rot = $urandom_range(NUM_STOPS - 1);
    for (k = 0; k < NUM_STOPS; k++) begin
      idx = 3'((k + rot) % NUM_STOPS);
      push_stop_write(idx, set_pos[idx], rgba_t'($urandom));
    end

    for (k = 0; k < PHASE_ITEMS - NUM_STOPS; k++) begin
      if ($urandom_range(99) < 20) begin
        idx = 3'($urandom);
        lo = (idx == 0) ? 0 : int'(planned_pos[idx-1]);
        hi = (idx == NUM_STOPS - 1) ? 65535 : int'(planned_pos[idx+1]);
        if (phase % 4 != 3 && lo <= hi && $urandom_range(9) != 0)
          v = int'($urandom_range(hi, lo));
        else
          v = int'($urandom_range(65535));
        push_stop_write(idx, POS_W'(v), rgba_t'($urandom));
      end else begin
        j = $urandom_range(NUM_STOPS - 1);
        case ($urandom_range(9))
          0, 1, 2, 3, 4: v = int'($urandom_range(65535));
          5, 6, 7: begin
            v = int'(planned_pos[j]) + int'($urandom_range(4)) - 2;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
          end
          8: v = ($urandom_range(1) == 0) ? 0 : 65535;
          default: begin
            v = (j == NUM_STOPS - 1) ? int'(planned_pos[j])
                                      : (int'(planned_pos[j]) + int'(planned_pos[j+1])) / 2;
          end
        endcase
        push_sample(POS_W'(v));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // With no stops in use the reset solid colour comes back.
    push_sample(16'h0000);
    push_sample(16'hFFFF);

    // Sorted table with a repeated position in the middle and at the end.
    push_stop_write(3'd0, 16'h0000, 32'h00000000);
    push_stop_write(3'd1, 16'h1000, 32'hFFFFFFFF);
    push_stop_write(3'd2, 16'h1000, 32'h80402010);
    push_stop_write(3'd3, 16'h4000, 32'h11F00FAA);
    push_stop_write(3'd4, 16'h8000, 32'hFF000000);
    push_stop_write(3'd5, 16'hC000, 32'h00FFFF00);
    push_stop_write(3'd6, 16'hFFFF, 32'hFF00FF00);
    push_stop_write(3'd7, 16'hFFFF, 32'h00FF00FF);
    wait_until_drained();
    write_register(REG_STOP_COUNT, 8'd8);
    write_register(REG_SOLID_RED, 8'hFF);
    write_register(REG_SOLID_GREEN, 8'h00);
    write_register(REG_SOLID_BLUE, 8'hFF);
    write_register(REG_SOLID_ALPHA, 8'h00);
    end_register_writes();

    push_sample(16'h0000);
    push_sample(16'h0001);
    push_sample(16'h0800);
    push_sample(16'h0FFF);
    push_sample(16'h1000);
    push_sample(16'h1001);
    push_sample(16'h3FFF);
    push_sample(16'h6000);
    push_sample(16'hBFFF);
    push_sample(16'hFFFE);
    push_sample(16'hFFFF);

    for (int p = 0; p < NUM_PHASES; p++) run_random_phase(p);
    wait_until_drained();

    if (error_count == 0) $display("** multi_stop_gradient_sampler_core: PASSED **");
    else $display("** multi_stop_gradient_sampler_core: FAILED **");
    $finish;
  end

endmodule
